// ----- design/rbfwt_pkg.sv -----
// Shared types, constants and lookup tables of the RBF waypoint target block.
package rbfwt_pkg;

   // Field widths of the transfers and registers.
   localparam int COORD_W   = 32;
   localparam int INDEX_W   = 5;
   localparam int COUNT_W   = 6;
   localparam int SCALE_W   = 16;
   localparam int QUOT_W    = 32;
   localparam int TAB_W     = 17;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   // Parameter defaults.
   localparam int DEF_MAX_WAYPOINTS = 32;
   localparam int DEF_FRAC_BITS     = 16;

   // Register reset values.
   localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd1;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd3200;

   // Register indexes on the configuration port.
   localparam logic CSR_IDX_COUNT = 1'b0;
   localparam logic CSR_IDX_SCALE = 1'b1;

   // Command codes of an input transfer.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Sequencer states of a query.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_FLUSH,
      ST_LAST,
      ST_DIV,
      ST_DONE
   } state_type;

   // exp(-i/16) in Q1.16 for i from 0 to 16.
   function automatic logic [TAB_W-1:0] exp_frac_lookup(input logic [4:0] i);
      logic [TAB_W-1:0] v;
      case (i)
         5'd0:    v = 17'd65536;
         5'd1:    v = 17'd61565;
         5'd2:    v = 17'd57835;
         5'd3:    v = 17'd54331;
         5'd4:    v = 17'd51039;
         5'd5:    v = 17'd47947;
         5'd6:    v = 17'd45042;
         5'd7:    v = 17'd42313;
         5'd8:    v = 17'd39750;
         5'd9:    v = 17'd37341;
         5'd10:   v = 17'd35079;
         5'd11:   v = 17'd32954;
         5'd12:   v = 17'd30957;
         5'd13:   v = 17'd29081;
         5'd14:   v = 17'd27319;
         5'd15:   v = 17'd25664;
         5'd16:   v = 17'd24110;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

   // exp(-n) in Q1.16 for n from 0 to 11; larger arguments give zero.
   function automatic logic [TAB_W-1:0] exp_int_lookup(input logic [3:0] n);
      logic [TAB_W-1:0] v;
      case (n)
         4'd0:    v = 17'd65536;
         4'd1:    v = 17'd24110;
         4'd2:    v = 17'd8869;
         4'd3:    v = 17'd3263;
         4'd4:    v = 17'd1200;
         4'd5:    v = 17'd442;
         4'd6:    v = 17'd162;
         4'd7:    v = 17'd60;
         4'd8:    v = 17'd22;
         4'd9:    v = 17'd8;
         4'd10:   v = 17'd3;
         4'd11:   v = 17'd1;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- design/rbfwt_if.sv -----
// Handshake channels for the request and response transfers.
interface rbfwt_req_if
   import rbfwt_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic                      command;
   logic        [INDEX_W-1:0] waypoint_index;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;

   modport source (output valid, command, waypoint_index, pos_x, pos_y, input ready);
   modport sink   (input valid, command, waypoint_index, pos_x, pos_y, output ready);
endinterface

interface rbfwt_rsp_if
   import rbfwt_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] target_x;
   logic signed [COORD_W-1:0] target_y;
   logic                      valid_res;

   modport source (output valid, target_x, target_y, valid_res, input ready);
   modport sink   (input valid, target_x, target_y, valid_res, output ready);
endinterface

// ----- design/rbfwt_div.sv -----
// Restoring divider giving a 32-bit quotient, one bit per cycle.
module rbfwt_div
   import rbfwt_pkg::*;
#(
   parameter int DIVD_W = 56,
   parameter int DEN_W  = 23
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DEN_W-1:0]  divisor,
   output logic              done,
   output logic [QUOT_W-1:0] quotient
);

   localparam int STEP_W = $clog2(QUOT_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DIVD_W-1:0] rem_ff, rem_in;
   logic [DIVD_W-1:0] dvs_ff, dvs_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic              fits;

   // The dividend is below the divisor times 2^32, so 32 steps cover the quotient.
   assign fits = (rem_ff >= dvs_ff);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = dividend;
         dvs_in  = DIVD_W'(divisor) << (QUOT_W - 1);
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dvs_ff;
         end
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         dvs_in  = dvs_ff >> 1;
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(QUOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ----- design/rbf_waypoint_target.sv -----
// Top level of the normalised Gaussian RBF waypoint target block.
//
//   Channel    Direction  Carries
//   req_chan   in         command, waypoint_index, pos_x, pos_y
//   rsp_chan   out        target_x, target_y, valid_res (one per query)
//   csr_*      in/out     waypoint_count, gauss_scale (APB-style)
//
// A query makes one table read per waypoint through the single memory read
// port, passes the reads through an eight-stage weight pipeline, then runs the
// bit-serial dividers.
// Reset is synchronous; the waypoint table itself is not cleared.
// Requests are taken only while no query is in progress; a finished result
// waits in the response register, and writes are still taken meanwhile.
module rbf_waypoint_target
   import rbfwt_pkg::*;
#(
   parameter int MAX_WAYPOINTS = DEF_MAX_WAYPOINTS,
   parameter int FRAC_BITS     = DEF_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   rbfwt_req_if.sink          req_chan,
   rbfwt_rsp_if.source        rsp_chan,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [CSR_AW-1:0]  csr_paddr,
   input  logic [CSR_DW-1:0]  csr_pwdata,
   output logic [CSR_DW-1:0]  csr_prdata,
   output logic               csr_pready
);

   localparam int AW     = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
   localparam int CNT_W  = AW + 1;
   localparam int PT_W   = 2 * COORD_W;
   localparam int MAG_W  = COORD_W;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int D2_W   = SQ_W - FRAC_BITS + 1;
   localparam int PR_W   = D2_W + SCALE_W;
   localparam int N_W    = PR_W - 8 - FRAC_BITS;
   localparam int WPR_W  = 2 * TAB_W;
   localparam int MUL_W  = TAB_W + 1 + COORD_W;
   localparam int ACC_W  = 48 + AW + 1;
   localparam int DEN_W  = TAB_W + AW;
   localparam int DIVD_W = ACC_W + 1;

   // ---------------------------------------------------------------- registers
   logic [COUNT_W-1:0] count_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic               csr_wr;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
         scale_ff <= SCALE_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            CSR_IDX_COUNT: count_ff <= csr_pwdata[COUNT_W-1:0];
            CSR_IDX_SCALE: scale_ff <= csr_pwdata[SCALE_W-1:0];
            default:       count_ff <= count_ff;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (csr_paddr[2])
         CSR_IDX_COUNT: csr_prdata = CSR_DW'(count_ff);
         CSR_IDX_SCALE: csr_prdata = CSR_DW'(scale_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- control
   state_type state_ff, state_in;
   logic      req_take, query_take, write_take;
   logic      rd_en, flush_en, div_start, rsp_load;
   logic      pipe_busy, div_done;
   logic      rsp_valid_ff;
   logic [CNT_W-1:0] walk_ff, cnt_ff;
   logic [DEN_W-1:0] den_ff;
   logic      have_prev_ff;

   assign req_take   = req_chan.valid && req_chan.ready;
   assign query_take = req_take && (req_chan.command == CMD_QUERY);
   assign write_take = req_take && (req_chan.command == CMD_WRITE);

   // Next state of the query sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (query_take) state_in = ST_WALK;
         ST_WALK:  if (walk_ff == cnt_ff) state_in = ST_DRAIN;
         ST_DRAIN: if (!pipe_busy) state_in = ST_FLUSH;
         ST_FLUSH: state_in = ST_LAST;
         ST_LAST:  if (!pipe_busy) state_in = (den_ff != '0) ? ST_DIV : ST_DONE;
         ST_DIV:   if (div_done) state_in = ST_DONE;
         ST_DONE:  if (!rsp_valid_ff || rsp_chan.ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      req_chan.ready = 1'b0;
      rd_en          = 1'b0;
      flush_en       = 1'b0;
      div_start      = 1'b0;
      rsp_load       = 1'b0;
      case (state_ff)
         ST_IDLE:  req_chan.ready = 1'b1;
         ST_WALK:  rd_en = (walk_ff != cnt_ff);
         ST_FLUSH: flush_en = have_prev_ff;
         ST_LAST:  div_start = !pipe_busy && (den_ff != '0);
         ST_DONE:  rsp_load = !rsp_valid_ff || rsp_chan.ready;
         default:  rd_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Latch the robot position and the number of waypoints in use.
   logic signed [COORD_W-1:0] rx_ff, ry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff <= '0;
         cnt_ff  <= '0;
      end else if (query_take) begin
         walk_ff <= '0;
         if (32'(count_ff) > 32'(MAX_WAYPOINTS)) begin
            cnt_ff <= CNT_W'(MAX_WAYPOINTS);
         end else begin
            cnt_ff <= CNT_W'(count_ff);
         end
      end else if (rd_en) begin
         walk_ff <= walk_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (query_take) begin
         rx_ff <= req_chan.pos_x;
         ry_ff <= req_chan.pos_y;
      end
   end

   // ---------------------------------------------------------------- table
   logic [PT_W-1:0] table_mem [MAX_WAYPOINTS];
   logic [PT_W-1:0] rd_data_ff;
   logic            s1v_ff;

   // Write port for waypoint transfers; slots beyond the table are dropped.
   always_ff @(posedge clock) begin
      if (write_take && (32'(req_chan.waypoint_index) < 32'(MAX_WAYPOINTS))) begin
         table_mem[AW'(req_chan.waypoint_index)] <= {req_chan.pos_x, req_chan.pos_y};
      end
   end

   // Read port, data registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_mem[walk_ff[AW-1:0]];
      end
   end

   // ---------------------------------------------------------------- weights
   logic              s2v_ff, s3v_ff, s4v_ff, s5v_ff, s6v_ff, s7v_ff, s8v_ff, a1v_ff;
   logic [PT_W-1:0]   pt2_ff, pt3_ff, pt4_ff, pt5_ff, pt6_ff, pt7_ff, pt8_ff;
   logic [COORD_W:0]  dx, dy;
   logic [MAG_W-1:0]  mx, my;
   logic [MAG_W-1:0]  mx_ff, my_ff;
   logic [SQ_W-1:0]   sqx_ff, sqy_ff;
   logic [D2_W-1:0]   d2_ff;
   logic [PR_W-1:0]   pr_ff;
   logic [N_W-1:0]    n_big;
   logic [FRAC_BITS-1:0] frac;
   logic [15:0]       f16;
   logic [TAB_W-1:0]  fa, fb;
   logic [29:0]       interp;
   logic [TAB_W-1:0]  fa_ff, t_ff;
   logic [3:0]        n_ff;
   logic              zero_ff;
   logic [TAB_W-1:0]  g, e;
   logic [WPR_W-1:0]  wpr_ff;
   logic [WPR_W:0]    wsum;
   logic [TAB_W-1:0]  w_ff;

   // Distance magnitudes from the robot to the waypoint just read.
   always_comb begin
      dx = {rx_ff[COORD_W-1], rx_ff} - {rd_data_ff[PT_W-1], rd_data_ff[PT_W-1:COORD_W]};
      dy = {ry_ff[COORD_W-1], ry_ff} - {rd_data_ff[COORD_W-1], rd_data_ff[COORD_W-1:0]};
      mx = dx[COORD_W] ? MAG_W'(-dx) : dx[MAG_W-1:0];
      my = dy[COORD_W] ? MAG_W'(-dy) : dy[MAG_W-1:0];
   end

   // Split the scaled distance into integer and fraction parts of the exponent.
   always_comb begin
      n_big  = pr_ff[PR_W-1:8+FRAC_BITS];
      frac   = pr_ff[8+FRAC_BITS-1:8];
      f16    = 16'({frac, 16'b0} >> FRAC_BITS);
      fa     = exp_frac_lookup({1'b0, f16[15:12]});
      fb     = exp_frac_lookup(5'({1'b0, f16[15:12]} + 5'd1));
      interp = 30'(fa - fb) * 30'(f16[11:0]) + 30'd2048;
   end

   // Fraction interpolation and integer factor.
   always_comb begin
      g    = fa_ff - t_ff;
      e    = zero_ff ? '0 : exp_int_lookup(n_ff);
      wsum = (WPR_W + 1)'(wpr_ff) + (WPR_W + 1)'(32768);
   end

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1v_ff <= 1'b0;
         s2v_ff <= 1'b0;
         s3v_ff <= 1'b0;
         s4v_ff <= 1'b0;
         s5v_ff <= 1'b0;
         s6v_ff <= 1'b0;
         s7v_ff <= 1'b0;
         s8v_ff <= 1'b0;
      end else begin
         s1v_ff <= rd_en;
         s2v_ff <= s1v_ff;
         s3v_ff <= s2v_ff;
         s4v_ff <= s3v_ff;
         s5v_ff <= s4v_ff;
         s6v_ff <= s5v_ff;
         s7v_ff <= s6v_ff;
         s8v_ff <= s7v_ff;
      end
   end

   // Weight pipeline payload: square, sum, scale, interpolate, combine, round.
   always_ff @(posedge clock) begin
      mx_ff   <= mx;
      my_ff   <= my;
      pt2_ff  <= rd_data_ff;
      sqx_ff  <= SQ_W'(mx_ff) * SQ_W'(mx_ff);
      sqy_ff  <= SQ_W'(my_ff) * SQ_W'(my_ff);
      pt3_ff  <= pt2_ff;
      d2_ff   <= D2_W'(sqx_ff[SQ_W-1:FRAC_BITS]) + D2_W'(sqy_ff[SQ_W-1:FRAC_BITS]);
      pt4_ff  <= pt3_ff;
      pr_ff   <= PR_W'(d2_ff) * PR_W'(scale_ff);
      pt5_ff  <= pt4_ff;
      fa_ff   <= fa;
      t_ff    <= interp[28:12];
      n_ff    <= n_big[3:0];
      zero_ff <= (n_big >= N_W'(12));
      pt6_ff  <= pt5_ff;
      wpr_ff  <= WPR_W'(e) * WPR_W'(g);
      pt7_ff  <= pt6_ff;
      w_ff    <= wsum[TAB_W+15:16];
      pt8_ff  <= pt7_ff;
   end

   assign pipe_busy = s1v_ff || s2v_ff || s3v_ff || s4v_ff || s5v_ff || s6v_ff
                      || s7v_ff || s8v_ff || a1v_ff;

   // ---------------------------------------------------------------- sums
   logic [TAB_W-1:0]          prev_w_ff;
   logic [PT_W-1:0]           prev_pt_ff;
   logic [PT_W-1:0]           mul_pt;
   logic signed [MUL_W-1:0]   mulx_ff, muly_ff;
   logic signed [ACC_W-1:0]   numx_ff, numy_ff;

   // Each weight pairs with the following waypoint; the last pairs with itself.
   assign mul_pt = flush_en ? prev_pt_ff : pt8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         a1v_ff       <= 1'b0;
         den_ff       <= '0;
         numx_ff      <= '0;
         numy_ff      <= '0;
      end else if (query_take) begin
         have_prev_ff <= 1'b0;
         a1v_ff       <= 1'b0;
         den_ff       <= '0;
         numx_ff      <= '0;
         numy_ff      <= '0;
      end else begin
         a1v_ff <= (s8v_ff && have_prev_ff) || flush_en;
         if (s8v_ff) begin
            have_prev_ff <= 1'b1;
            den_ff       <= den_ff + DEN_W'(w_ff);
         end else if (flush_en) begin
            have_prev_ff <= 1'b0;
         end
         if (a1v_ff) begin
            numx_ff <= numx_ff + ACC_W'(mulx_ff);
            numy_ff <= numy_ff + ACC_W'(muly_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s8v_ff) begin
         prev_w_ff  <= w_ff;
         prev_pt_ff <= pt8_ff;
      end
      mulx_ff <= $signed({1'b0, prev_w_ff}) * $signed(mul_pt[PT_W-1:COORD_W]);
      muly_ff <= $signed({1'b0, prev_w_ff}) * $signed(mul_pt[COORD_W-1:0]);
   end

   // ---------------------------------------------------------------- divide
   logic              negx, negy;
   logic [ACC_W-1:0]  magx, magy;
   logic [DIVD_W-1:0] divdx, divdy;
   logic [QUOT_W-1:0] qx, qy;
   logic              donex, doney;

   // Round to nearest with halves away from zero: divide the magnitude plus half.
   always_comb begin
      negx  = numx_ff[ACC_W-1];
      negy  = numy_ff[ACC_W-1];
      magx  = negx ? ACC_W'(-numx_ff) : ACC_W'(numx_ff);
      magy  = negy ? ACC_W'(-numy_ff) : ACC_W'(numy_ff);
      divdx = DIVD_W'(magx) + DIVD_W'(den_ff >> 1);
      divdy = DIVD_W'(magy) + DIVD_W'(den_ff >> 1);
   end

   rbfwt_div #(
      .DIVD_W (DIVD_W),
      .DEN_W  (DEN_W)
   ) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (divdx),
      .divisor  (den_ff),
      .done     (donex),
      .quotient (qx)
   );

   rbfwt_div #(
      .DIVD_W (DIVD_W),
      .DEN_W  (DEN_W)
   ) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (divdy),
      .divisor  (den_ff),
      .done     (doney),
      .quotient (qy)
   );

   assign div_done = donex && doney;

   // ---------------------------------------------------------------- response
   logic signed [COORD_W-1:0] tx_ff, ty_ff;
   logic                      vres_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         vres_ff <= (den_ff != '0);
         if (den_ff == '0) begin
            tx_ff <= '0;
            ty_ff <= '0;
         end else begin
            tx_ff <= negx ? -$signed(qx) : $signed(qx);
            ty_ff <= negy ? -$signed(qy) : $signed(qy);
         end
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.target_x  = tx_ff;
   assign rsp_chan.target_y  = ty_ff;
   assign rsp_chan.valid_res = vres_ff;

endmodule

// ----- test/tb_rbf_waypoint_target.sv -----
// Self-checking testbench of the RBF waypoint target block with its own target predictor.
module tb_rbf_waypoint_target;
   import rbfwt_pkg::*;

   localparam int NUM_SLOTS   = DEF_MAX_WAYPOINTS;
   localparam int PHASE_ITEMS = 170;
   localparam int IDLE_LIMIT  = 5000;
   localparam logic [CSR_AW-1:0] ADDR_COUNT = {CSR_IDX_COUNT, 2'b00};
   localparam logic [CSR_AW-1:0] ADDR_SCALE = {CSR_IDX_SCALE, 2'b00};

   typedef struct packed {
      logic signed [COORD_W-1:0] target_x;
      logic signed [COORD_W-1:0] target_y;
      logic                      valid_res;
   } target_type;

   // Predicts the interpolated target of each query and checks the responses in order.
   class target_predictor;
      longint             slot_x [NUM_SLOTS];
      longint             slot_y [NUM_SLOTS];
      logic [COUNT_W-1:0] count_reg;
      logic [SCALE_W-1:0] scale_reg;
      target_type         pending_targets [$];
      int                 fail_count;
      longint unsigned    exp_whole [12];
      longint unsigned    exp_part [17];

      function new();
         exp_whole = '{65536, 24110, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1};
         exp_part  = '{65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313, 39750,
                       37341, 35079, 32954, 30957, 29081, 27319, 25664, 24110};
         count_reg  = COUNT_RESET;
         scale_reg  = SCALE_RESET;
         fail_count = 0;
         foreach (slot_x[k]) begin
            slot_x[k] = 0;
            slot_y[k] = 0;
         end
      endfunction

      function longint unsigned square_q(longint d);
         longint unsigned m;
         m = (d < 0) ? longint'(-d) : d;
         return (m * m) >> 16;
      endfunction

      // Gaussian weight of a squared distance: integer and fractional exponent lookups.
      function longint unsigned gauss(longint unsigned d2);
         logic [81:0]     prod;
         longint unsigned p, e, n, f, i, r, g;
         prod = {18'd0, d2} * {66'd0, scale_reg};
         p = (prod[81:64] != 0) ? '1 : prod[63:0];
         e = p >> 8;
         n = e >> 16;
         if (n >= 12) return 0;
         f = e & 16'hFFFF;
         i = f >> 12;
         r = f & 4095;
         g = exp_part[i] - (((exp_part[i] - exp_part[i+1]) * r + 2048) >> 12);
         return (exp_whole[n] * g + 32768) >> 16;
      endfunction

      function logic [31:0] rounded_quotient(longint num, longint unsigned den);
         longint unsigned mag, q;
         mag = (num < 0) ? longint'(-num) : num;
         q = (mag + den / 2) / den;
         if (num < 0) q = -q;
         return q[31:0];
      endfunction

      // Notes an accepted request: a write updates the table, a query adds an expected target.
      function void note_request(logic cmd, logic [INDEX_W-1:0] idx,
                                 logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py);
         int              cnt, nx;
         longint unsigned den, w;
         longint          numx, numy, rx, ry;
         target_type      t;
         rx = px;
         ry = py;
         if (cmd == CMD_WRITE) begin
            slot_x[idx] = rx;
            slot_y[idx] = ry;
            return;
         end
         cnt = (count_reg > NUM_SLOTS) ? NUM_SLOTS : count_reg;
         den = 0; numx = 0; numy = 0;
         for (int j = 0; j < cnt; j++) begin
            nx = (j + 1 < cnt) ? j + 1 : j;
            w = gauss(square_q(rx - slot_x[j]) + square_q(ry - slot_y[j]));
            den += w;
            numx += longint'(w) * slot_x[nx];
            numy += longint'(w) * slot_y[nx];
         end
         if (den == 0) begin
            t = '0;
         end else begin
            t.target_x  = rounded_quotient(numx, den);
            t.target_y  = rounded_quotient(numy, den);
            t.valid_res = 1'b1;
         end
         pending_targets.push_back(t);
      endfunction

      // Compares one response with the oldest expected target.
      function void check_target(target_type got);
         target_type want;
         if (pending_targets.size() == 0) begin
            $error("response transfer with no query outstanding");
            fail_count++;
            return;
         end
         want = pending_targets.pop_front();
         if (got.target_x !== want.target_x) begin
            $error("target_x: expected %0d, got %0d", want.target_x, got.target_x);
            fail_count++;
         end
         if (got.target_y !== want.target_y) begin
            $error("target_y: expected %0d, got %0d", want.target_y, got.target_y);
            fail_count++;
         end
         if (got.valid_res !== want.valid_res) begin
            $error("valid_res: expected %0d, got %0d", want.valid_res, got.valid_res);
            fail_count++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_psel, csr_penable, csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   rbfwt_req_if req_chan ();
   rbfwt_rsp_if rsp_chan ();

   rbf_waypoint_target i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   target_predictor predictor = new();

   int          send_idle_pct;
   int          recv_stall_pct;
   int          quiet_cycles;
   logic [31:0] written_mask;
   logic [31:0] gen_x [NUM_SLOTS];
   logic [31:0] gen_y [NUM_SLOTS];
   int          gen_count;

   // Clock generation.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Receiver readiness, stalling at the rate of the current phase.
   always @(negedge clock) begin
      if (!reset) rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Observes accepted transfers on both channels.
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         predictor.note_request(req_chan.command, req_chan.waypoint_index,
                                req_chan.pos_x, req_chan.pos_y);
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         predictor.check_target({rsp_chan.target_x, rsp_chan.target_y, rsp_chan.valid_res});
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Presents one request, with random idle cycles before it; returns after the falling edge.
   task automatic send_request(logic cmd, logic [INDEX_W-1:0] idx, logic [31:0] px,
                               logic [31:0] py);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.command        <= cmd;
      req_chan.waypoint_index <= idx;
      req_chan.pos_x          <= px;
      req_chan.pos_y          <= py;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      if (cmd == CMD_WRITE) begin
         written_mask[idx] = 1'b1;
         gen_x[idx] = px;
         gen_y[idx] = py;
      end
   endtask

   // Waits until no query is outstanding and the block has had time to settle.
   task automatic wait_quiet();
      req_chan.valid <= 1'b0;
      while (predictor.pending_targets.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   // One APB write: setup cycle, then access cycle.
   task automatic csr_write(logic [CSR_AW-1:0] addr, logic [CSR_DW-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_COUNT) predictor.count_reg = data[COUNT_W-1:0];
      else predictor.scale_reg = data[SCALE_W-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic configure(int count, int scale);
      wait_quiet();
      csr_write(ADDR_COUNT, count);
      csr_write(ADDR_SCALE, scale);
      gen_count = (count > NUM_SLOTS) ? NUM_SLOTS : count;
   endtask

   function automatic logic [31:0] near(logic [31:0] base);
      int span;
      span = 1 << $urandom_range(4, 18);
      return base + $urandom_range(0, 2 * span) - span;
   endfunction

   // One random request: mostly clustered waypoints and queries close to them.
   task automatic random_request();
      int          missing, slot, base;
      logic [31:0] px, py;
      missing = -1;
      for (int k = gen_count - 1; k >= 0; k--)
         if (!written_mask[k]) missing = k;
      if ($urandom_range(99) < 40 && missing < 0) begin
         base = (gen_count == 0) ? 0 : $urandom_range(gen_count - 1);
         if ($urandom_range(99) < 15) begin
            px = $urandom;
            py = $urandom;
         end else begin
            px = near(gen_x[base]);
            py = near(gen_y[base]);
         end
         send_request(CMD_QUERY, INDEX_W'($urandom_range(31)), px, py);
      end else begin
         slot = (missing >= 0) ? missing : $urandom_range(31);
         base = $urandom_range(31);
         if ($urandom_range(99) < 15 || !written_mask[base]) begin
            px = $urandom;
            py = $urandom;
            if ($urandom_range(1)) begin
               px = near(32'd0);
               py = near(32'd0);
            end
         end else begin
            px = near(gen_x[base]);
            py = near(gen_y[base]);
         end
         send_request(CMD_WRITE, INDEX_W'(slot), px, py);
      end
   endtask

   initial begin
      int phase_count [8] = '{32, 5, 63, 2, 17, 0, 32, 8};
      int phase_scale [8] = '{3200, 256, 0, 65535, 1, 3200, 800, 12800};
      int phase_send  [8] = '{0, 50, 0, 36, 0, 50, 0, 36};
      int phase_stall [8] = '{0, 0, 50, 36, 0, 0, 50, 36};
      reset          = 1'b1;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      req_chan.valid = 1'b0;
      req_chan.command        = CMD_WRITE;
      req_chan.waypoint_index = '0;
      req_chan.pos_x          = '0;
      req_chan.pos_y          = '0;
      rsp_chan.ready = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      written_mask   = '0;
      gen_count      = 1;
      foreach (gen_x[k]) begin
         gen_x[k] = '0;
         gen_y[k] = '0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: coordinate extremes, far and near queries, zero count, zero scale.
      send_request(CMD_WRITE, 0, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_request(CMD_QUERY, 0, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_request(CMD_QUERY, 31, 32'h80000000, 32'h80000000);
      send_request(CMD_WRITE, 1, 32'h80000000, 32'h80000000);
      send_request(CMD_WRITE, 2, 32'h00000000, 32'h00000000);
      send_request(CMD_WRITE, 3, 32'h00004000, 32'hFFFFC000);
      send_request(CMD_WRITE, 31, 32'h12345678, 32'hEDCBA987);
      send_request(CMD_QUERY, 0, 32'h00000000, 32'h00000000);
      configure(4, 3200);
      send_request(CMD_QUERY, 0, 32'h00000000, 32'h00000000);
      send_request(CMD_QUERY, 0, 32'h00002000, 32'hFFFFE000);
      send_request(CMD_QUERY, 0, 32'h80000000, 32'h80000000);
      configure(0, 3200);
      send_request(CMD_QUERY, 0, 32'h00000000, 32'h00000000);
      configure(4, 0);
      send_request(CMD_QUERY, 0, 32'h7FFFFFFF, 32'h80000000);
      configure(4, 65535);
      send_request(CMD_QUERY, 0, 32'h00000010, 32'h00000000);
      send_request(CMD_QUERY, 0, 32'h00000000, 32'h00000000);

      // Random phases with their own settings and idling.
      for (int ph = 0; ph < 8; ph++) begin
         configure(phase_count[ph], phase_scale[ph]);
         send_idle_pct  = phase_send[ph];
         recv_stall_pct = phase_stall[ph];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // At the midpoint of each phase, the sender holds off until all outstanding targets have been returned.
            if (n == PHASE_ITEMS / 2) begin
               req_chan.valid <= 1'b0;
               while (predictor.pending_targets.size() != 0) @(negedge clock);
            end else begin
               random_request();
            end
         end
      end

      // Drain and report.
      req_chan.valid <= 1'b0;
      while (predictor.pending_targets.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (predictor.fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
